// ===== rtl/core/kocnt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kocnt_pkg: shared types and constants of the keyword occurrence counter
// Keyword table, result kinds, sequencing phases and the word hit struct.
// ----------------------------------------------------------------------------
package kocnt_pkg;

	// longest word is MAX_WORD_LEN-1 characters
	localparam int MAX_WORD_LEN = 100;
	localparam logic [7:0] WORD_CAP = 8'(MAX_WORD_LEN - 1);

	localparam int NUM_KEYS = 3;
	localparam logic [1:0] KEY_AUTO  = 2'd0;
	localparam logic [1:0] KEY_BREAK = 2'd1;
	localparam logic [1:0] KEY_CASE  = 2'd2;

	typedef enum logic [1:0] {
		KIND_HIT    = 2'd0,
		KIND_REPORT = 2'd1,
		KIND_EMPTY  = 2'd2
	} kind_t;

	typedef enum logic {
		PH_WORD   = 1'b0,
		PH_REPORT = 1'b1
	} phase_t;

	// outcome of ending a word
	typedef struct packed {
		logic       hit;
		logic [1:0] idx;
	} hit_t;

	// keyword lengths
	function automatic logic [7:0] key_len(input logic [1:0] k);
		case (k)
			KEY_AUTO:  key_len = 8'd4;
			KEY_BREAK: key_len = 8'd5;
			KEY_CASE:  key_len = 8'd4;
			default:   key_len = 8'd0;
		endcase
	endfunction

	// keyword character at position p, zero past the end
	function automatic logic [7:0] key_char(input logic [1:0] k, input logic [7:0] p);
		logic [7:0] c;
		c = 8'h00;
		case (k)
			KEY_AUTO: begin
				case (p)
					8'd0:    c = "a";
					8'd1:    c = "u";
					8'd2:    c = "t";
					8'd3:    c = "o";
					default: c = 8'h00;
				endcase
			end
			KEY_BREAK: begin
				case (p)
					8'd0:    c = "b";
					8'd1:    c = "r";
					8'd2:    c = "e";
					8'd3:    c = "a";
					8'd4:    c = "k";
					default: c = 8'h00;
				endcase
			end
			KEY_CASE: begin
				case (p)
					8'd0:    c = "c";
					8'd1:    c = "a";
					8'd2:    c = "s";
					8'd3:    c = "e";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		key_char = c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/keyword_occurrence_counter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_occurrence_counter_top: keyword occurrence counter
// Counts the keywords auto, break and case in a text byte stream and reports
// the counts at end of text.
// ----------------------------------------------------------------------------
// channel  handshake            payload
// in       in_valid/in_ready    text_byte, end_of_text
// out      out_valid/out_ready  kind, key_index, occurrences, last_result
//
// a text byte goes from the input register through the word tracker to the result register
// an end of text beat first finishes the word, then gives one report result
// per step, set by the report sequencer
// reset clears word state and all counts; counts persist across end of text
// a stalled output holds the input register; one more beat can wait there
// ----------------------------------------------------------------------------
module keyword_occurrence_counter_top
	import kocnt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_text,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [1:0]       key_index,
	output logic [31:0]      occurrences,
	output logic             last_result
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;

	phase_t      phase_q;
	logic [2:0]  done_q;
	logic [31:0] counts_q [NUM_KEYS];

	logic        out_valid_q;
	kind_t       kind_q;
	logic [1:0]  idx_q;
	logic [31:0] occ_q;
	logic        last_q;

	logic        out_free;
	logic        step;
	logic        word_step;
	logic        step_final;
	hit_t        hit;
	logic [31:0] hit_count;
	logic [2:0]  nz;
	logic [2:0]  pend;
	logic [2:0]  rest;
	logic [1:0]  sel;

	logic        res_valid;
	kind_t       res_kind;
	logic [1:0]  res_idx;
	logic [31:0] res_occ;
	logic        res_last;

	assign out_free  = !out_valid_q || out_ready;
	assign step      = valid_s1 && out_free;
	assign word_step = step && (!eot_s1 || (phase_q == PH_WORD));

	kocnt_word u_word (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (word_step),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.hit         (hit)
	);

	// saturating count of the hit keyword
	always_comb begin
		hit_count = counts_q[hit.idx];
		if (hit_count != 32'hFFFF_FFFF)
			hit_count = hit_count + 32'd1;
	end

	// pick the next keyword to report
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++)
			nz[k] = (counts_q[k] != 32'd0);
		pend = nz & ~done_q;
		sel  = KEY_AUTO;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (pend[k])
				sel = 2'(k);
		end
		rest = pend & ~(3'b001 << sel);
	end

	// result of this step
	always_comb begin
		res_valid  = 1'b0;
		res_kind   = KIND_HIT;
		res_idx    = hit.idx;
		res_occ    = hit_count;
		res_last   = !eot_s1;
		step_final = !eot_s1;
		if (!eot_s1 || (phase_q == PH_WORD)) begin
			res_valid = hit.hit;
		end else if (nz == 3'b000) begin
			res_valid  = 1'b1;
			res_kind   = KIND_EMPTY;
			res_idx    = KEY_AUTO;
			res_occ    = 32'd0;
			res_last   = 1'b1;
			step_final = 1'b1;
		end else begin
			res_valid  = 1'b1;
			res_kind   = KIND_REPORT;
			res_idx    = sel;
			res_occ    = counts_q[sel];
			res_last   = (rest == 3'b000);
			step_final = (rest == 3'b000);
		end
	end

	assign in_ready = !valid_s1 || (step && step_final);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	// report sequencer and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WORD;
			done_q  <= 3'b000;
			for (int k = 0; k < NUM_KEYS; k++)
				counts_q[k] <= 32'd0;
		end else if (step) begin
			if (word_step && hit.hit)
				counts_q[hit.idx] <= hit_count;
			if (eot_s1) begin
				if (phase_q == PH_WORD) begin
					phase_q <= PH_REPORT;
					done_q  <= 3'b000;
				end else if (step_final) begin
					phase_q <= PH_WORD;
					done_q  <= 3'b000;
				end else begin
					done_q <= done_q | (3'b001 << sel);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			kind_q <= res_kind;
			idx_q  <= res_idx;
			occ_q  <= res_occ;
			last_q <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign key_index   = idx_q;
	assign occurrences = occ_q;
	assign last_result = last_q;

	// checks
	a_report_needs_eot: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (phase_q == PH_REPORT)) |-> eot_s1)
		else $error("report phase without end of text");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_HIT)) |-> (occurrences != 32'd0))
		else $error("hit result with zero count");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_EMPTY)) |-> (last_result && (occurrences == 32'd0)))
		else $error("empty report not final or nonzero");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted beat not held in input register");

endmodule
`default_nettype wire

// ===== rtl/core/kocnt_word.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kocnt_word: word tracker
// Collects the current word's length and keyword prefix matches and reports
// which keyword, if any, a word equals in the step that ends it.
// ----------------------------------------------------------------------------
module kocnt_word
	import kocnt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	output hit_t            hit
);

	logic       inside_q;
	logic [7:0] len_q;
	logic [2:0] match_q;

	logic       inside_d;
	logic [7:0] len_d;
	logic [2:0] match_d;

	logic       is_alnum;
	logic       is_letter;
	logic [7:0] base_len;
	logic [2:0] base_match;
	logic [7:0] app_len;
	logic [2:0] app_match;
	logic       fin;
	logic [7:0] fin_len;
	logic [2:0] fin_match;

	// character classes
	always_comb begin
		is_letter = ((text_byte >= "a") && (text_byte <= "z")) ||
		            ((text_byte >= "A") && (text_byte <= "Z"));
		is_alnum  = is_letter || ((text_byte >= "0") && (text_byte <= "9"));
	end

	// append the byte to the word
	always_comb begin
		base_len   = inside_q ? len_q : 8'd0;
		base_match = inside_q ? match_q : 3'b111;
		app_match  = base_match;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if ((base_len >= key_len(2'(k))) || (key_char(2'(k), base_len) != text_byte))
				app_match[k] = 1'b0;
		end
		app_len = base_len + 8'd1;
	end

	// next word state and word end
	always_comb begin
		inside_d  = inside_q;
		len_d     = len_q;
		match_d   = match_q;
		fin       = 1'b0;
		fin_len   = len_q;
		fin_match = match_q;
		if (end_of_text || (inside_q && !is_alnum)) begin
			fin      = inside_q;
			inside_d = 1'b0;
			len_d    = 8'd0;
			match_d  = 3'b111;
		end else if (inside_q || is_letter) begin
			if (app_len >= WORD_CAP) begin
				fin       = 1'b1;
				fin_len   = app_len;
				fin_match = app_match;
				inside_d  = 1'b0;
				len_d     = 8'd0;
				match_d   = 3'b111;
			end else begin
				inside_d = 1'b1;
				len_d    = app_len;
				match_d  = app_match;
			end
		end
	end

	// first keyword that the finished word equals
	always_comb begin
		hit = '0;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (fin && fin_match[k] && (fin_len == key_len(2'(k)))) begin
				hit.hit = 1'b1;
				hit.idx = 2'(k);
			end
		end
	end

	// word state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			len_q    <= 8'd0;
			match_q  <= 3'b111;
		end else if (step) begin
			inside_q <= inside_d;
			len_q    <= len_d;
			match_q  <= match_d;
		end
	end

endmodule
`default_nettype wire

// ===== sim/tb_keyword_occurrence_counter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyword_occurrence_counter_top: self-checking bench for the keyword counter
// Feeds text beats through a random-gap driver, predicts hits and end of text
// reports in the bench, and checks every output beat in order, field by field.
// ----------------------------------------------------------------------------
module tb_keyword_occurrence_counter_top;
	import kocnt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_LIMIT  = 10;

	// one text beat waiting to be driven
	typedef struct {
		logic [7:0] ch;
		logic       eot;
		logic       wait_idle;
	} text_beat_t;

	// one expected output beat
	typedef struct {
		kind_t       kind;
		logic [1:0]  key_index;
		logic [31:0] occurrences;
		logic        last_result;
	} tally_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  text_byte = 8'h00;
	logic        end_of_text = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [1:0]  key_index;
	logic [31:0] occurrences;
	logic        last_result;

	text_beat_t text_q [$];
	tally_t     tally_q [$];

	// keyword table, indexed by KEY_AUTO, KEY_BREAK, KEY_CASE
	string kw_text [NUM_KEYS] = '{"auto", "break", "case"};

	// bench copy of the word state and counts
	logic        in_word = 1'b0;
	logic [7:0]  word_len = 8'd0;
	logic [2:0]  prefix_ok = 3'b111;
	logic [31:0] counts [NUM_KEYS] = '{default: 32'd0};

	int   in_beats = 0;
	int   issued = 0;
	int   out_beats = 0;
	int   seen_out = 0;
	int   tx_gap = 0;
	int   rx_stall = 0;
	int   rx_wait;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	int   mismatches = 0;
	int   cycles = 0;
	logic next_waits = 1'b0;

	keyword_occurrence_counter_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.key_index   (key_index),
		.occurrences (occurrences),
		.last_result (last_result)
	);

	always #10 clk = ~clk;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_letter(c) || (c >= "0" && c <= "9");
	endfunction

	// wait states per beat, with calm stretches of no idling
	function automatic int pick_wait(input int count);
		if ((count / 64) % 3 == 1)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] rand_alnum();
		int r;
		r = $urandom_range(0, 61);
		return (r < 52) ? rand_letter() : 8'("0" + r - 52);
	endfunction

	// any byte that ends a word, high half included
	function automatic logic [7:0] rand_sep();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (is_alnum(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic push_tally(input kind_t k, input logic [1:0] idx, input logic [31:0] occ);
		tally_t t;
		t.kind = k;
		t.key_index = idx;
		t.occurrences = occ;
		t.last_result = 1'b0;
		tally_q.push_back(t);
	endtask

	// end the open word, counting a keyword hit
	task automatic close_word();
		if (in_word) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (prefix_ok[k] && word_len == kw_text[k].len()) begin
					if (counts[k] != 32'hFFFF_FFFF)
						counts[k] = counts[k] + 32'd1;
					push_tally(KIND_HIT, 2'(k), counts[k]);
					break;
				end
			end
		end
		in_word = 1'b0;
		word_len = 8'd0;
		prefix_ok = 3'b111;
	endtask

	// expected output beats for one accepted text beat
	task automatic count_keywords(input logic [7:0] ch, input logic eot);
		int   first;
		logic any;
		first = tally_q.size();
		if (eot) begin
			close_word();
			any = 1'b0;
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (counts[k] != 32'd0) begin
					push_tally(KIND_REPORT, 2'(k), counts[k]);
					any = 1'b1;
				end
			end
			if (!any)
				push_tally(KIND_EMPTY, 2'd0, 32'd0);
		end else if (in_word && !is_alnum(ch)) begin
			close_word();
		end else if (in_word || is_letter(ch)) begin
			if (!in_word) begin
				in_word = 1'b1;
				word_len = 8'd0;
				prefix_ok = 3'b111;
			end
			for (int k = 0; k < NUM_KEYS; k++)
				if (word_len >= kw_text[k].len() || kw_text[k][word_len] != ch)
					prefix_ok[k] = 1'b0;
			word_len = word_len + 8'd1;
			// word cap ends the word on the same beat
			if (word_len >= WORD_CAP)
				close_word();
		end
		if (tally_q.size() > first)
			tally_q[$].last_result = 1'b1;
	endtask

	task automatic push_byte(input logic [7:0] ch, input logic eot);
		text_beat_t b;
		b.ch = ch;
		b.eot = eot;
		b.wait_idle = next_waits;
		next_waits = 1'b0;
		text_q.push_back(b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0);
	endtask

	// a keyword, sometimes bent so that it misses
	task automatic push_keyword(input int k, input logic bend);
		int         len;
		int         mut;
		int         pos;
		logic [7:0] ch;
		len = kw_text[k].len();
		mut = bend ? $urandom_range(0, 9) : 9;
		pos = $urandom_range(0, len - 1);
		for (int i = 0; i < len; i++) begin
			ch = kw_text[k][i];
			if (mut == 0 && i == len - 1)
				break;
			if (mut == 2 && i == 0)
				ch = ch - 8'd32;
			if (mut == 3 && i == pos)
				ch = rand_letter();
			push_byte(ch, 1'b0);
		end
		if (mut == 1)
			push_byte(rand_alnum(), 1'b0);
	endtask

	// input and output monitor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			count_keywords(text_byte, end_of_text);
			in_beats <= in_beats + 1;
		end
		if (arst_n && out_valid && out_ready) begin
			out_beats <= out_beats + 1;
			if (tally_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("unexpected beat: kind %0d key %0d occ %0d last %0b",
						kind, key_index, occurrences, last_result);
			end else begin
				if (kind !== tally_q[0].kind || key_index !== tally_q[0].key_index
						|| occurrences !== tally_q[0].occurrences
						|| last_result !== tally_q[0].last_result) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
							tally_q[0].kind, tally_q[0].key_index, tally_q[0].occurrences,
							tally_q[0].last_result, kind, key_index, occurrences, last_result);
				end
				void'(tally_q.pop_front());
			end
		end
	end

	// run time limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// text driver
	always @(negedge clk) begin
		if (arst_n && !(in_valid && in_beats != issued)) begin
			if (tx_gap > 0) begin
				in_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (text_q.size() != 0 && !(text_q[0].wait_idle && tally_q.size() != 0)) begin
				in_valid <= 1'b1;
				text_byte <= text_q[0].ch;
				end_of_text <= text_q[0].eot;
				void'(text_q.pop_front());
				issued <= issued + 1;
				tx_gap <= pick_wait(issued);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off to back up the input
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && out_beats >= 10) begin
				hold_done <= 1'b1;
				hold_left <= 400;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				if (out_beats != seen_out) begin
					seen_out <= out_beats;
					rx_wait = pick_wait(out_beats);
				end else begin
					rx_wait = rx_stall;
				end
				if (rx_wait > 0) begin
					out_ready <= 1'b0;
					rx_stall <= rx_wait - 1;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int rand_items;
		int cap_runs;
		int sel;
		int n0;
		int len;
		logic counted;

		// directed: empty report, each keyword, terminators, full report
		push_byte(8'h00, 1'b1);
		push_text("auto,");
		push_text("break");
		push_byte(8'hFF, 1'b0);
		push_text("Case9 ");
		push_text("case");
		push_byte(8'h5A, 1'b1);
		push_byte(8'h00, 1'b0);
		push_text("7q");

		// random text, mostly keywords and near misses
		rand_items = 0;
		cap_runs = 0;
		while (rand_items < 90) begin
			n0 = text_q.size();
			counted = 1'b1;
			if (rand_items >= 50 && !next_waits && cap_runs >= 1 && rand_items < 60)
				next_waits = 1'b1;
			if (cap_runs < 2 && rand_items >= 40 * cap_runs + 30) begin
				// long word around the cap, then a keyword right behind it
				len = $urandom_range(WORD_CAP - 1, WORD_CAP + 2);
				push_byte(rand_letter(), 1'b0);
				for (int i = 1; i < len; i++)
					push_byte(rand_alnum(), 1'b0);
				push_keyword($urandom_range(0, NUM_KEYS - 1), 1'b0);
				push_byte(rand_sep(), 1'b0);
				cap_runs++;
				counted = 1'b0;
			end else begin
				sel = $urandom_range(0, 19);
				if (sel < 12) begin
					push_keyword($urandom_range(0, NUM_KEYS - 1), 1'b1);
					sel = $urandom_range(0, 19);
					if (sel < 17)
						push_byte(rand_sep(), 1'b0);
					else if (sel < 19)
						push_byte(8'($urandom_range(0, 255)), 1'b1);
				end else if (sel < 16) begin
					push_byte(rand_letter(), 1'b0);
					len = $urandom_range(0, 7);
					for (int i = 0; i < len; i++)
						push_byte(rand_alnum(), 1'b0);
					push_byte(rand_sep(), 1'b0);
				end else if (sel < 19) begin
					len = $urandom_range(1, 4);
					for (int i = 0; i < len; i++)
						push_byte(8'($urandom_range(0, 255)), 1'b0);
				end else begin
					push_byte(8'($urandom_range(0, 255)), 1'b1);
				end
			end
			if (counted)
				rand_items += text_q.size() - n0;
		end
		push_byte(8'($urandom_range(0, 255)), 1'b1);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (text_q.size() != 0 || in_beats != issued || in_valid)
			@(posedge clk);
		while (tally_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && tally_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
